### design/brf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Operation and status codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

   localparam int MODE_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 10;
   localparam int SIZE_W   = 4;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH  = 2'd0,
      MODE_POP   = 2'd1,
      MODE_BURST = 2'd2,
      MODE_CLEAR = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_RESP
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // request transfer: run the command, set up the result
      logic load_byte;  // move the fetched byte into the result, advance read
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic fetch;      // the request on the port needs a byte from the store
      logic more;       // the current burst still has bytes to remove
   } dp_sts_type;

endpackage
`default_nettype wire

### design/byte_ring_fifo_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_ring_fifo_core: byte FIFO over a power-of-two ring
// Push, pop, burst read and clear commands on one request stream; one or
// more results per command on the response stream.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one command per transfer: tuser is the mode, tdata the
//    byte to push and the burst length. rsp_* returns the results; tlast
//    marks the final result of a command.
//  - csr_wr_en/csr_wdata set log2 of the ring size in use (1..DEPTH_LOG2)
//    and empty the ring. Write it only while no command is in flight.
//  - Push, clear, a pop on an empty ring and an empty burst answer with
//    their result in the cycle after the request transfer.
//  - Pop and each burst byte first pass through the registered store read,
//    then the result is held on rsp until taken; each byte of a burst goes
//    through these steps in turn. A new item is not started before the
//    previous result is transferred, set by the single result register.
//  - A command is taken only after the last result of the previous one has
//    been transferred. A stalled receiver holds the result and the block.
//  - Reset empties the ring and sets the size to DEPTH_LOG2. The store
//    itself is not cleared; no byte is read before it was written.
// ----------------------------------------------------------------------------
module byte_ring_fifo_core
   import brf_pkg::*;
#(
   parameter int DEPTH_LOG2 = 10,
   parameter int MAX_BURST  = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // configuration
   input  wire logic              csr_wr_en,
   input  wire logic [SIZE_W-1:0] csr_wdata,   // size_log2
   // request stream
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [15:0]       req_tdata,   // [7:0] data_in, [14:8] max_bytes
   input  wire logic [1:0]        req_tuser,   // [1:0] mode
   // response stream
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [39:0]            rsp_tdata,   // [7:0] data_out, [14:8] burst_count,
                                               // [24:15] bytes_held, [34:25] bytes_free
   output logic [2:0]             rsp_tuser,   // [0] data_valid, [2:1] status
   output logic                   rsp_tlast    // last
);

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   logic [BYTE_W-1:0]   data_out;
   logic                data_valid;
   logic [STATUS_W-1:0] status;
   logic [COUNT_W-1:0]  burst_count;
   logic [HELD_W-1:0]   bytes_held;
   logic [HELD_W-1:0]   bytes_free;

   // sequence each command: capture, optional store read, hold result
   brf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_sts     (dp_sts),
      .dp_cmd     (dp_cmd)
   );

   // store, indices, size register and result fields
   brf_datapath #(
      .DEPTH_LOG2 (DEPTH_LOG2),
      .MAX_BURST  (MAX_BURST)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wdata       (csr_wdata),
      .req_mode        (req_tuser),
      .req_data_in     (req_tdata[7:0]),
      .req_max_bytes   (req_tdata[14:8]),
      .dp_cmd          (dp_cmd),
      .dp_sts          (dp_sts),
      .rsp_data_out    (data_out),
      .rsp_data_valid  (data_valid),
      .rsp_status      (status),
      .rsp_last        (rsp_tlast),
      .rsp_burst_count (burst_count),
      .rsp_bytes_held  (bytes_held),
      .rsp_bytes_free  (bytes_free)
   );

   // pack the result fields, lowest field first, pad to whole bytes
   assign rsp_tdata = {5'd0, bytes_free, bytes_held, burst_count, data_out};
   assign rsp_tuser = {status, data_valid};

`ifndef SYNTHESIS
   // one command at a time: never ready for a request while a result waits
   assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("request ready while a result is pending");

   // the final result of a command frees the request side at once
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready)
      else $error("block not ready after the final transfer of a command");

   // a burst count only comes with a removed byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (burst_count != '0)) |-> data_valid)
      else $error("burst count without a data byte");

   // full and empty reports end their command
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (status != STS_OK)) |-> (rsp_tlast && !data_valid))
      else $error("error status on a data or non-final result");
`endif

endmodule
`default_nettype wire

### design/brf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_ctrl: sequencing controller
// Takes one request, waits for a store read where needed, and holds each
// result until it is taken.
// ----------------------------------------------------------------------------
module brf_ctrl
   import brf_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   input  wire dp_sts_type dp_sts,
   output dp_cmd_type      dp_cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = dp_sts.fetch ? ST_FETCH : ST_RESP;
            end
         end
         ST_FETCH: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) begin
               state_in = dp_sts.more ? ST_FETCH : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready        = 1'b0;
      rsp_tvalid        = 1'b0;
      dp_cmd.capture    = 1'b0;
      dp_cmd.load_byte  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            dp_cmd.capture = req_tvalid;
         end
         ST_FETCH: begin
            dp_cmd.load_byte = 1'b1;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule
`default_nettype wire

### design/brf_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brf_datapath: ring store, indices and result register
// Holds the byte store, the read and write indices, the size register and
// the registered result fields.
// ----------------------------------------------------------------------------
module brf_datapath
   import brf_pkg::*;
#(
   parameter int DEPTH_LOG2 = 10,
   parameter int MAX_BURST  = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [SIZE_W-1:0]   csr_wdata,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [BYTE_W-1:0]   req_data_in,
   input  wire logic [COUNT_W-1:0]  req_max_bytes,
   input  wire dp_cmd_type          dp_cmd,
   output dp_sts_type               dp_sts,
   output logic [BYTE_W-1:0]        rsp_data_out,
   output logic                     rsp_data_valid,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_last,
   output logic [COUNT_W-1:0]       rsp_burst_count,
   output logic [HELD_W-1:0]        rsp_bytes_held,
   output logic [HELD_W-1:0]        rsp_bytes_free
);

   localparam int DEPTH = 1 << DEPTH_LOG2;
   localparam logic [SIZE_W-1:0]  SIZE_MAX  = SIZE_W'(DEPTH_LOG2);
   localparam logic [COUNT_W-1:0] BURST_MAX = COUNT_W'(MAX_BURST);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [DEPTH_LOG2-1:0] wr_ff, wr_in;
   logic [DEPTH_LOG2-1:0] rd_ff, rd_in;
   logic [COUNT_W-1:0]    n_ff, n_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  burst_ff, burst_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic                  valid_ff, valid_in;
   status_type            status_ff, status_in;
   logic                  last_ff, last_in;

   logic [DEPTH_LOG2-1:0] mask;
   logic [DEPTH_LOG2-1:0] held;
   logic [DEPTH_LOG2-1:0] wr_next;
   logic                  full;
   logic                  empty;
   logic [COUNT_W-1:0]    req_sat;
   logic [COUNT_W-1:0]    n_burst;
   logic [COUNT_W-1:0]    count_next;
   logic                  mem_we;
   mode_type              mode;

   assign mode       = mode_type'(req_mode);
   assign mask       = {DEPTH_LOG2{1'b1}} >> (SIZE_MAX - size_ff);
   assign held       = (wr_ff - rd_ff) & mask;
   assign wr_next    = (wr_ff + 1'b1) & mask;
   assign full       = (wr_next == rd_ff);
   assign empty      = (wr_ff == rd_ff);
   assign req_sat    = (req_max_bytes > BURST_MAX) ? BURST_MAX : req_max_bytes;
   assign n_burst    = (32'(req_sat) > 32'(held)) ? COUNT_W'(held) : req_sat;
   assign count_next = count_ff + 1'b1;
   assign mem_we     = dp_cmd.capture && (mode == MODE_PUSH) && !full;

   always_comb begin
      dp_sts.more = (count_ff != n_ff);
      unique case (mode)
         MODE_POP:   dp_sts.fetch = !empty;
         MODE_BURST: dp_sts.fetch = (n_burst != '0);
         default:    dp_sts.fetch = 1'b0;
      endcase
   end

   // store: one write port at the write index, registered read at the read index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_ff] <= req_data_in;
      end
      rd_data_ff <= mem[rd_ff];
   end

   always_comb begin
      size_in   = size_ff;
      wr_in     = wr_ff;
      rd_in     = rd_ff;
      n_in      = n_ff;
      count_in  = count_ff;
      burst_in  = burst_ff;
      data_in   = data_ff;
      valid_in  = valid_ff;
      status_in = status_ff;
      last_in   = last_ff;
      priority if (csr_wr_en) begin
         // saturate the size, empty the ring
         if (csr_wdata == '0) begin
            size_in = SIZE_W'(1);
         end else if (csr_wdata > SIZE_MAX) begin
            size_in = SIZE_MAX;
         end else begin
            size_in = csr_wdata;
         end
         wr_in = '0;
         rd_in = '0;
      end else if (dp_cmd.capture) begin
         n_in      = '0;
         count_in  = '0;
         burst_in  = (mode == MODE_BURST);
         data_in   = '0;
         valid_in  = 1'b0;
         status_in = STS_OK;
         last_in   = 1'b1;
         unique case (mode)
            MODE_PUSH: begin
               if (full) begin
                  status_in = STS_FULL;
               end else begin
                  wr_in = wr_next;
               end
            end
            MODE_POP: begin
               if (empty) begin
                  status_in = STS_EMPTY;
               end else begin
                  n_in = COUNT_W'(1);
               end
            end
            MODE_BURST: begin
               n_in = n_burst;
            end
            MODE_CLEAR: begin
               rd_in = wr_ff;
            end
            default: begin
               n_in = '0;
            end
         endcase
      end else if (dp_cmd.load_byte) begin
         data_in   = rd_data_ff;
         valid_in  = 1'b1;
         status_in = STS_OK;
         count_in  = count_next;
         last_in   = (count_next == n_ff);
         rd_in     = (rd_ff + 1'b1) & mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff  <= SIZE_MAX;
         wr_ff    <= '0;
         rd_ff    <= '0;
         n_ff     <= '0;
         count_ff <= '0;
      end else begin
         size_ff  <= size_in;
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         n_ff     <= n_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      burst_ff  <= burst_in;
      data_ff   <= data_in;
      valid_ff  <= valid_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_data_out    = data_ff;
   assign rsp_data_valid  = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_last        = last_ff;
   assign rsp_burst_count = burst_ff ? count_ff : '0;
   assign rsp_bytes_held  = HELD_W'(held);
   assign rsp_bytes_free  = HELD_W'(mask - held);

endmodule
`default_nettype wire
